// ===== rtl/r2y_pkg.sv =====
// Shared types, constants and coefficients for the RGB to YCbCr 4:2:0 converter.
package r2y_pkg;

    // Frame size limits and field widths
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int CFG_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int PIX_W      = 8;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int WDIM_W     = $clog2(MAX_WIDTH + 1);
    localparam int HDIM_W     = $clog2(MAX_HEIGHT + 1);
    localparam int DIM_MAX_W  = (WDIM_W > HDIM_W) ? WDIM_W : HDIM_W;
    localparam int CMP_W      = ((DIM_MAX_W > CFG_W) ? DIM_MAX_W : CFG_W) + 1;
    localparam int LIDX_W     = 22;
    localparam int CIDX_W     = 20;

    // Line store of horizontal chroma pair sums
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int LINE_AW    = $clog2(LINE_DEPTH);
    localparam int PAIR_W     = PIX_W + 1;
    localparam int LINE_W     = 2 * PAIR_W;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Q16 BT.601 coefficients and offsets; every sum stays in [0, 2^24)
    localparam int ACC_W = 24;
    localparam logic [ACC_W-1:0] K_YR  = 24'd16843;
    localparam logic [ACC_W-1:0] K_YG  = 24'd33030;
    localparam logic [ACC_W-1:0] K_YB  = 24'd6423;
    localparam logic [ACC_W-1:0] K_CBR = 24'd9699;
    localparam logic [ACC_W-1:0] K_CBG = 24'd19071;
    localparam logic [ACC_W-1:0] K_CBB = 24'd28770;
    localparam logic [ACC_W-1:0] K_CRR = 24'd28770;
    localparam logic [ACC_W-1:0] K_CRG = 24'd24117;
    localparam logic [ACC_W-1:0] K_CRB = 24'd4653;
    localparam logic [ACC_W-1:0] OFF_Y = 24'd1048576;
    localparam logic [ACC_W-1:0] OFF_C = 24'd8388608;

    // Register reset values
    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = 12'd640;
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 12'd480;
    localparam logic [PIX_W-1:0] RST_CLIP_LOW     = 8'd16;
    localparam logic [PIX_W-1:0] RST_LUMA_MAX     = 8'd235;
    localparam logic [PIX_W-1:0] RST_CHROMA_MAX   = 8'd240;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_CLIP_LOW     = 3'd2,
        REG_LUMA_MAX     = 3'd3,
        REG_CHROMA_MAX   = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [CFG_W-1:0] image_width;
        logic [CFG_W-1:0] image_height;
        logic [PIX_W-1:0] clip_low;
        logic [PIX_W-1:0] luma_max;
        logic [PIX_W-1:0] chroma_max;
    } cfg_t;

    // Role of a pixel in its 2x2 chroma block
    typedef enum logic [1:0] {
        KIND_LEFT  = 2'd0,  // even column: becomes the left half of a pair
        KIND_STORE = 2'd1,  // odd column, even row: pair sum goes to the line
        KIND_MERGE = 2'd2   // odd column, odd row: block average goes out
    } pix_kind_t;

    typedef struct packed {
        logic [PIX_W-1:0]  red;
        logic [PIX_W-1:0]  green;
        logic [PIX_W-1:0]  blue;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [WDIM_W-1:0] width;
        pix_kind_t         kind;
        logic              last;
    } pix_entry_t;

endpackage

// ===== rtl/rgb_to_ycbcr_420.sv =====
// Top level of the RGB to BT.601 YCbCr converter with 4:2:0 chroma subsampling.
//
// Converts one RGB pixel per clock in raster order. Each accepted input beat
// produces exactly one output beat carrying luma and its plane index; on odd
// rows and odd columns the beat also carries the 2x2-averaged Cb and Cr and
// the chroma plane index. Throughput is one pixel per cycle while out_ready
// stays high; that rate is set by the single conversion pipeline and the one
// write port and one read port of the pair-sum line store. Each accepted
// input beat is written into the queue, then passes through the product,
// sum/clip, line store and output registers in that order. A four-entry queue
// decouples the input from output stalls. The line store needs no clearing
// pass after reset: each odd row reads only what its even row wrote.
// Configuration registers must only be written while no pixel is in flight.
module rgb_to_ycbcr_420 (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [r2y_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [r2y_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [r2y_pkg::PIX_W-1:0]      red,
    input  logic [r2y_pkg::PIX_W-1:0]      green,
    input  logic [r2y_pkg::PIX_W-1:0]      blue,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [r2y_pkg::PIX_W-1:0]      luma,
    output logic [r2y_pkg::LIDX_W-1:0]     luma_index,
    output logic                           chroma_valid,
    output logic [r2y_pkg::PIX_W-1:0]      cb_value,
    output logic [r2y_pkg::PIX_W-1:0]      cr_value,
    output logic [r2y_pkg::CIDX_W-1:0]     chroma_index,
    output logic                           frame_end
);
    import r2y_pkg::*;

    cfg_t       cfg_reg;
    logic       q_push, q_full, q_pop, q_empty;
    pix_entry_t q_in, q_out;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width  <= RST_IMAGE_WIDTH;
            cfg_reg.image_height <= RST_IMAGE_HEIGHT;
            cfg_reg.clip_low     <= RST_CLIP_LOW;
            cfg_reg.luma_max     <= RST_LUMA_MAX;
            cfg_reg.chroma_max   <= RST_CHROMA_MAX;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  cfg_reg.image_width  <= cfg_wdata;
                REG_IMAGE_HEIGHT: cfg_reg.image_height <= cfg_wdata;
                REG_CLIP_LOW:     cfg_reg.clip_low     <= cfg_wdata[PIX_W-1:0];
                REG_LUMA_MAX:     cfg_reg.luma_max     <= cfg_wdata[PIX_W-1:0];
                REG_CHROMA_MAX:   cfg_reg.chroma_max   <= cfg_wdata[PIX_W-1:0];
                default:          ;
            endcase
        end
    end

    // Front end: position tracking and classification
    r2y_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .red      (red),
        .green    (green),
        .blue     (blue),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_in)
    );

    // Decoupling queue
    r2y_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (q_out),
        .empty      (q_empty)
    );

    // Back end: conversion, subsampling, output
    r2y_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .q_entry      (q_out),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .luma         (luma),
        .luma_index   (luma_index),
        .chroma_valid (chroma_valid),
        .cb_value     (cb_value),
        .cr_value     (cr_value),
        .chroma_index (chroma_index),
        .frame_end    (frame_end)
    );

endmodule

// ===== rtl/r2y_ram.sv =====
// Generic simple dual-port RAM with registered read.
module r2y_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/r2y_front.sv =====
// Front end: accepts pixel beats, tracks raster position and classifies each pixel.
module r2y_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  r2y_pkg::cfg_t            cfg,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [r2y_pkg::PIX_W-1:0] red,
    input  logic [r2y_pkg::PIX_W-1:0] green,
    input  logic [r2y_pkg::PIX_W-1:0] blue,
    input  logic                     q_full,
    output logic                     q_push,
    output r2y_pkg::pix_entry_t      q_entry
);
    import r2y_pkg::*;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [CMP_W-1:0] w_raw, w_used;
    logic [CMP_W-1:0] h_raw, h_used;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [CMP_W-1:0] col_inc, row_inc;
    logic             last;

    // Effective frame size: width even, both clamped to [2, MAX]
    always_comb
    begin
        w_raw = CMP_W'({cfg.image_width[CFG_W-1:1], 1'b0});
        if (w_raw < CMP_W'(2))
        begin
            w_used = CMP_W'(2);
        end
        else if (w_raw > CMP_W'(MAX_WIDTH))
        begin
            w_used = CMP_W'(MAX_WIDTH);
        end
        else
        begin
            w_used = w_raw;
        end

        h_raw = CMP_W'(cfg.image_height);
        if (h_raw < CMP_W'(2))
        begin
            h_used = CMP_W'(2);
        end
        else if (h_raw > CMP_W'(MAX_HEIGHT))
        begin
            h_used = CMP_W'(MAX_HEIGHT);
        end
        else
        begin
            h_used = h_raw;
        end
    end

    // Position of this beat; counters left beyond a shrunk size restart
    always_comb
    begin
        col     = (CMP_W'(col_reg) >= w_used) ? '0 : col_reg;
        row     = (CMP_W'(row_reg) >= h_used) ? '0 : row_reg;
        col_inc = CMP_W'(col) + CMP_W'(1);
        row_inc = CMP_W'(row) + CMP_W'(1);
        last    = (col_inc == w_used) && (row_inc == h_used);

        if (col_inc >= w_used)
        begin
            col_next = '0;
            row_next = (row_inc >= h_used) ? '0 : row_inc[ROW_W-1:0];
        end
        else
        begin
            col_next = col_inc[COL_W-1:0];
            row_next = row;
        end
    end

    // Handshake into the queue
    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready;

    // Queue entry
    always_comb
    begin
        q_entry.red   = red;
        q_entry.green = green;
        q_entry.blue  = blue;
        q_entry.col   = col;
        q_entry.row   = row;
        q_entry.width = w_used[WDIM_W-1:0];
        q_entry.last  = last;
        if (!col[0])
        begin
            q_entry.kind = KIND_LEFT;
        end
        else if (!row[0])
        begin
            q_entry.kind = KIND_STORE;
        end
        else
        begin
            q_entry.kind = KIND_MERGE;
        end
    end

    // Raster counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (q_push)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Last pixel of a frame wraps both counters to the origin
    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        q_push && q_entry.last |=> (col_reg == '0) && (row_reg == '0))
        else $error("counters did not wrap after frame end");

endmodule

// ===== rtl/r2y_fifo.sv =====
// Short queue of classified pixels between the front end and the back end.
module r2y_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  r2y_pkg::pix_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output r2y_pkg::pix_entry_t pop_entry,
    output logic                empty
);
    import r2y_pkg::*;

    pix_entry_t         entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;

    assign full      = (count_reg == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign empty     = (count_reg == '0);
    assign pop_entry = entry_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (FIFO_AW + 1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (FIFO_AW + 1)'(1);
            end
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (FIFO_AW + 1)'(FIFO_DEPTH))
        else $error("queue fill count out of range");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + (FIFO_AW + 1)'(1))
        else $error("queue lost a beat on push");

endmodule

// ===== rtl/r2y_back.sv =====
// Back end: color conversion pipeline, chroma pair line store and output register.
module r2y_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  r2y_pkg::cfg_t              cfg,
    input  logic                       q_empty,
    output logic                       q_pop,
    input  r2y_pkg::pix_entry_t        q_entry,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [r2y_pkg::PIX_W-1:0]  luma,
    output logic [r2y_pkg::LIDX_W-1:0] luma_index,
    output logic                       chroma_valid,
    output logic [r2y_pkg::PIX_W-1:0]  cb_value,
    output logic [r2y_pkg::PIX_W-1:0]  cr_value,
    output logic [r2y_pkg::CIDX_W-1:0] chroma_index,
    output logic                       frame_end
);
    import r2y_pkg::*;

    localparam int LP_W = ROW_W + WDIM_W;
    localparam int CP_W = (ROW_W - 1) + (WDIM_W - 1);

    // Clip to [lo, hi]; with crossed limits, below lo gives lo, else hi
    function automatic logic [PIX_W-1:0] clip8(
        input logic [PIX_W-1:0] v,
        input logic [PIX_W-1:0] lo,
        input logic [PIX_W-1:0] hi
    );
        logic [PIX_W-1:0] r;
        if (v < lo)
        begin
            r = lo;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    logic adv;

    // Stage 1: products
    logic              s1_valid_reg;
    logic [ACC_W-1:0]  s1_yr_reg, s1_yg_reg, s1_yb_reg;
    logic [ACC_W-1:0]  s1_cbr_reg, s1_cbg_reg, s1_cbb_reg;
    logic [ACC_W-1:0]  s1_crr_reg, s1_crg_reg, s1_crb_reg;
    logic [LIDX_W-1:0] s1_lprod_reg;
    logic [CIDX_W-1:0] s1_cprod_reg;
    logic [COL_W-1:0]  s1_col_reg;
    pix_kind_t         s1_kind_reg;
    logic              s1_last_reg;

    // Stage 2: sums, truncation and clipping
    logic              s2_valid_reg;
    logic [PIX_W-1:0]  s2_y_reg, s2_cb_reg, s2_cr_reg;
    logic [LIDX_W-1:0] s2_lidx_reg;
    logic [CIDX_W-1:0] s2_cidx_reg;
    logic [COL_W-1:0]  s2_col_reg;
    pix_kind_t         s2_kind_reg;
    logic              s2_last_reg;
    logic [ACC_W-1:0]  sum_y, sum_cb, sum_cr;

    // Stage 3: pair sums and line store access
    logic              s3_valid_reg;
    logic [PIX_W-1:0]  s3_y_reg;
    logic [PAIR_W-1:0] s3_sb_reg, s3_sr_reg;
    logic [LIDX_W-1:0] s3_lidx_reg;
    logic [CIDX_W-1:0] s3_cidx_reg;
    pix_kind_t         s3_kind_reg;
    logic              s3_last_reg;
    logic [PIX_W-1:0]  left_cb_reg, left_cr_reg;
    logic [PAIR_W-1:0] pair_cb, pair_cr;
    logic              ram_we, ram_re;
    logic [LINE_W-1:0] ram_rdata;
    logic [PAIR_W:0]   blk_cb, blk_cr;

    // Output register
    logic              out_valid_reg;
    logic [PIX_W-1:0]  luma_reg;
    logic [LIDX_W-1:0] luma_index_reg;
    logic              chroma_valid_reg;
    logic [PIX_W-1:0]  cb_value_reg, cr_value_reg;
    logic [CIDX_W-1:0] chroma_index_reg;
    logic              frame_end_reg;

    // Whole pipeline moves when the output slot is free or being taken
    assign adv   = !out_valid_reg || out_ready;
    assign q_pop = adv && !q_empty;

    // Stage valid bits and left-neighbor chroma
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            left_cb_reg   <= '0;
            left_cr_reg   <= '0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= !q_empty;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
            if (s2_valid_reg)
            begin
                left_cb_reg <= s2_cb_reg;
                left_cr_reg <= s2_cr_reg;
            end
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_yr_reg    <= ACC_W'(q_entry.red)   * K_YR;
            s1_yg_reg    <= ACC_W'(q_entry.green) * K_YG;
            s1_yb_reg    <= ACC_W'(q_entry.blue)  * K_YB;
            s1_cbr_reg   <= ACC_W'(q_entry.red)   * K_CBR;
            s1_cbg_reg   <= ACC_W'(q_entry.green) * K_CBG;
            s1_cbb_reg   <= ACC_W'(q_entry.blue)  * K_CBB;
            s1_crr_reg   <= ACC_W'(q_entry.red)   * K_CRR;
            s1_crg_reg   <= ACC_W'(q_entry.green) * K_CRG;
            s1_crb_reg   <= ACC_W'(q_entry.blue)  * K_CRB;
            s1_lprod_reg <= LIDX_W'(LP_W'(q_entry.row) * LP_W'(q_entry.width));
            s1_cprod_reg <= CIDX_W'(CP_W'(q_entry.row[ROW_W-1:1])
                                    * CP_W'(q_entry.width[WDIM_W-1:1]));
            s1_col_reg   <= q_entry.col;
            s1_kind_reg  <= q_entry.kind;
            s1_last_reg  <= q_entry.last;
        end
    end

    // Sums are always non-negative, so truncation is the upper byte
    always_comb
    begin
        sum_y  = OFF_Y + s1_yr_reg + s1_yg_reg + s1_yb_reg;
        sum_cb = OFF_C - s1_cbr_reg - s1_cbg_reg + s1_cbb_reg;
        sum_cr = OFF_C + s1_crr_reg - s1_crg_reg - s1_crb_reg;
    end

    // Stage 2 payload
    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
        begin
            s2_y_reg    <= clip8(sum_y[ACC_W-1:16], cfg.clip_low, cfg.luma_max);
            s2_cb_reg   <= clip8(sum_cb[ACC_W-1:16], cfg.clip_low, cfg.chroma_max);
            s2_cr_reg   <= clip8(sum_cr[ACC_W-1:16], cfg.clip_low, cfg.chroma_max);
            s2_lidx_reg <= s1_lprod_reg + LIDX_W'(s1_col_reg);
            s2_cidx_reg <= s1_cprod_reg + CIDX_W'(s1_col_reg[COL_W-1:1]);
            s2_col_reg  <= s1_col_reg;
            s2_kind_reg <= s1_kind_reg;
            s2_last_reg <= s1_last_reg;
        end
    end

    // Horizontal pair sums and line store control
    assign pair_cb = PAIR_W'(left_cb_reg) + PAIR_W'(s2_cb_reg);
    assign pair_cr = PAIR_W'(left_cr_reg) + PAIR_W'(s2_cr_reg);
    assign ram_we  = adv && s2_valid_reg && (s2_kind_reg == KIND_STORE);
    assign ram_re  = adv && s2_valid_reg && (s2_kind_reg == KIND_MERGE);

    r2y_ram #(
        .WIDTH (LINE_W),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s2_col_reg[COL_W-1:1]),
        .wdata ({pair_cr, pair_cb}),
        .re    (ram_re),
        .raddr (s2_col_reg[COL_W-1:1]),
        .rdata (ram_rdata)
    );

    // Stage 3 payload
    always_ff @(posedge clk)
    begin
        if (adv && s2_valid_reg)
        begin
            s3_y_reg    <= s2_y_reg;
            s3_sb_reg   <= pair_cb;
            s3_sr_reg   <= pair_cr;
            s3_lidx_reg <= s2_lidx_reg;
            s3_cidx_reg <= s2_cidx_reg;
            s3_kind_reg <= s2_kind_reg;
            s3_last_reg <= s2_last_reg;
        end
    end

    // 2x2 block sums; the average is the sum shifted down by two
    assign blk_cb = (PAIR_W + 1)'(ram_rdata[PAIR_W-1:0]) + (PAIR_W + 1)'(s3_sb_reg);
    assign blk_cr = (PAIR_W + 1)'(ram_rdata[LINE_W-1:PAIR_W]) + (PAIR_W + 1)'(s3_sr_reg);

    // Output register
    always_ff @(posedge clk)
    begin
        if (adv && s3_valid_reg)
        begin
            luma_reg       <= s3_y_reg;
            luma_index_reg <= s3_lidx_reg;
            frame_end_reg  <= s3_last_reg;
            if (s3_kind_reg == KIND_MERGE)
            begin
                chroma_valid_reg <= 1'b1;
                cb_value_reg     <= blk_cb[PAIR_W:2];
                cr_value_reg     <= blk_cr[PAIR_W:2];
                chroma_index_reg <= s3_cidx_reg;
            end
            else
            begin
                chroma_valid_reg <= 1'b0;
                cb_value_reg     <= '0;
                cr_value_reg     <= '0;
                chroma_index_reg <= '0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign luma         = luma_reg;
    assign luma_index   = luma_index_reg;
    assign chroma_valid = chroma_valid_reg;
    assign cb_value     = cb_value_reg;
    assign cr_value     = cr_value_reg;
    assign chroma_index = chroma_index_reg;
    assign frame_end    = frame_end_reg;

    // Chroma only at odd column; width is even so the luma index is odd
    a_chroma_odd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && chroma_valid_reg |-> luma_index_reg[0])
        else $error("chroma beat at even luma index");

    a_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !chroma_valid_reg
            |-> (cb_value_reg == '0) && (cr_value_reg == '0) && (chroma_index_reg == '0))
        else $error("chroma fields not cleared");

    a_line_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("line store read and write in one cycle");

endmodule

// ===== bench/ycbcr_420_checker.sv =====
// Scoreboard for rgb_to_ycbcr_420: mirrors the color conversion and 4:2:0 averaging, checks every output beat.
module ycbcr_420_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [r2y_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [r2y_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [r2y_pkg::PIX_W-1:0]     red,
    input  logic [r2y_pkg::PIX_W-1:0]     green,
    input  logic [r2y_pkg::PIX_W-1:0]     blue,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [r2y_pkg::PIX_W-1:0]     luma,
    input  logic [r2y_pkg::LIDX_W-1:0]    luma_index,
    input  logic                          chroma_valid,
    input  logic [r2y_pkg::PIX_W-1:0]     cb_value,
    input  logic [r2y_pkg::PIX_W-1:0]     cr_value,
    input  logic [r2y_pkg::CIDX_W-1:0]    chroma_index,
    input  logic                          frame_end,
    output int                            mismatch_count,
    output int                            pixels_in_flight
);
    import r2y_pkg::*;

    // BT.601 studio range in Q16: round(c * 65536)
    localparam int Y_OFFSET = 16 * 65536;
    localparam int C_OFFSET = 128 * 65536;
    localparam int KY_R     = 16843;
    localparam int KY_G     = 33030;
    localparam int KY_B     = 6423;
    localparam int KCB_R    = 9699;
    localparam int KCB_G    = 19071;
    localparam int KCB_B    = 28770;
    localparam int KCR_R    = 28770;
    localparam int KCR_G    = 24117;
    localparam int KCR_B    = 4653;

    typedef struct packed {
        logic [PIX_W-1:0]  luma;
        logic [LIDX_W-1:0] luma_index;
        logic              chroma_valid;
        logic [PIX_W-1:0]  cb_value;
        logic [PIX_W-1:0]  cr_value;
        logic [CIDX_W-1:0] chroma_index;
        logic              frame_end;
    } ycc_beat_t;

    ycc_beat_t expected_beats[$];

    // mirrored registers
    logic [CFG_W-1:0] image_width;
    logic [CFG_W-1:0] image_height;
    logic [PIX_W-1:0] clip_low;
    logic [PIX_W-1:0] luma_max;
    logic [PIX_W-1:0] chroma_max;

    // raster position, left half of the current pair, even-row pair sums {Cr, Cb}
    int               col_count;
    int               row_count;
    int               left_cb;
    int               left_cr;
    logic [LINE_W-1:0] pair_sums [LINE_DEPTH];

    function automatic int width_used(input int raw);
        int w;
        w = raw & ~1;
        if (w < 2) w = 2;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int height_used(input int raw);
        int h;
        h = raw;
        if (h < 2) h = 2;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        return h;
    endfunction

    // drop the 16 fraction bits toward zero, then clamp; a low limit above hi still wins below it
    function automatic int trunc_clip(input int sum, input int hi);
        int v;
        if (sum < 0) v = -((-sum) >>> 16);
        else v = sum >>> 16;
        if (v < int'(clip_low)) return int'(clip_low);
        if (v > hi) return hi;
        return v;
    endfunction

    // one pixel in, one expected beat out; advances the raster state
    function automatic ycc_beat_t convert_pixel(input logic [PIX_W-1:0] r8,
                                                input logic [PIX_W-1:0] g8,
                                                input logic [PIX_W-1:0] b8);
        ycc_beat_t         beat;
        int                w, h, r, g, b, y, cb, cr;
        int                cb_pair, cr_pair, above_cb, above_cr, slot, idx;
        logic [LINE_W-1:0] above;
        w = width_used(image_width);
        h = height_used(image_height);
        // a smaller frame size restarts counters that fell outside it
        if (col_count >= w) col_count = 0;
        if (row_count >= h) row_count = 0;
        r = r8;
        g = g8;
        b = b8;
        y  = trunc_clip(Y_OFFSET + KY_R * r + KY_G * g + KY_B * b, luma_max);
        cb = trunc_clip(C_OFFSET - KCB_R * r - KCB_G * g + KCB_B * b, chroma_max);
        cr = trunc_clip(C_OFFSET + KCR_R * r - KCR_G * g - KCR_B * b, chroma_max);

        beat = '0;
        beat.luma = y[PIX_W-1:0];
        idx = row_count * w + col_count;
        beat.luma_index = idx[LIDX_W-1:0];

        // odd column closes a horizontal pair: store on even rows, average on odd rows
        slot = (col_count >> 1) % LINE_DEPTH;
        if (col_count % 2 == 1) begin
            cb_pair = left_cb + cb;
            cr_pair = left_cr + cr;
            if (row_count % 2 == 0) begin
                pair_sums[slot] = {cr_pair[PAIR_W-1:0], cb_pair[PAIR_W-1:0]};
            end
            else begin
                above = pair_sums[slot];
                above_cb = above[PAIR_W-1:0];
                above_cr = above[LINE_W-1:PAIR_W];
                cb_pair = (above_cb + cb_pair) >> 2;
                cr_pair = (above_cr + cr_pair) >> 2;
                idx = (row_count >> 1) * (w >> 1) + (col_count >> 1);
                beat.chroma_valid = 1'b1;
                beat.cb_value = cb_pair[PIX_W-1:0];
                beat.cr_value = cr_pair[PIX_W-1:0];
                beat.chroma_index = idx[CIDX_W-1:0];
            end
        end
        left_cb = cb;
        left_cr = cr;
        beat.frame_end = (col_count == w - 1) && (row_count == h - 1);

        col_count++;
        if (col_count >= w) begin
            col_count = 0;
            row_count++;
            if (row_count >= h) row_count = 0;
        end
        return beat;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : scoreboard
        ycc_beat_t want;
        if (!rst_n) begin
            image_width = RST_IMAGE_WIDTH;
            image_height = RST_IMAGE_HEIGHT;
            clip_low = RST_CLIP_LOW;
            luma_max = RST_LUMA_MAX;
            chroma_max = RST_CHROMA_MAX;
            col_count = 0;
            row_count = 0;
            left_cb = 0;
            left_cr = 0;
            expected_beats.delete();
            mismatch_count = 0;
            pixels_in_flight = 0;
        end
        else begin
            // output beat against the oldest expectation
            if (out_valid && out_ready) begin
                if (expected_beats.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual luma_index %0d",
                             $time, luma_index);
                    mismatch_count++;
                end
                else begin
                    want = expected_beats.pop_front();
                    check_field("luma", want.luma, luma);
                    check_field("luma_index", want.luma_index, luma_index);
                    check_field("chroma_valid", want.chroma_valid, chroma_valid);
                    check_field("cb_value", want.cb_value, cb_value);
                    check_field("cr_value", want.cr_value, cr_value);
                    check_field("chroma_index", want.chroma_index, chroma_index);
                    check_field("frame_end", want.frame_end, frame_end);
                end
            end

            // register writes
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_index))
                    REG_IMAGE_WIDTH:  image_width = cfg_wdata;
                    REG_IMAGE_HEIGHT: image_height = cfg_wdata;
                    REG_CLIP_LOW:     clip_low = cfg_wdata[PIX_W-1:0];
                    REG_LUMA_MAX:     luma_max = cfg_wdata[PIX_W-1:0];
                    REG_CHROMA_MAX:   chroma_max = cfg_wdata[PIX_W-1:0];
                    default: ;
                endcase
            end

            // input beat
            if (in_valid && in_ready)
                expected_beats.push_back(convert_pixel(red, green, blue));
            pixels_in_flight = expected_beats.size();
        end
    end

endmodule

// ===== bench/tb_rgb_to_ycbcr_420.sv =====
// Testbench top for rgb_to_ycbcr_420: pixel and register stimulus, flow control and verdict.
module tb_rgb_to_ycbcr_420;
    import r2y_pkg::*;

    localparam int PIXEL_BUDGET   = 1600;
    localparam int WIDE_PIXELS    = 500;
    localparam int DRAIN_CYCLES   = 8;
    localparam int STALL_CYCLES   = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 in_valid;
    logic                 in_ready;
    logic [PIX_W-1:0]     red;
    logic [PIX_W-1:0]     green;
    logic [PIX_W-1:0]     blue;
    logic                 out_valid;
    logic                 out_ready;
    logic [PIX_W-1:0]     luma;
    logic [LIDX_W-1:0]    luma_index;
    logic                 chroma_valid;
    logic [PIX_W-1:0]     cb_value;
    logic [PIX_W-1:0]     cr_value;
    logic [CIDX_W-1:0]    chroma_index;
    logic                 frame_end;
    int                   mismatch_count;
    int                   pixels_in_flight;

    // raster position as the block will see it; keeps odd rows on written line entries
    int raster_col;
    int raster_row;
    int frame_width;
    int frame_height;
    int pixels_sent = 0;
    bit sender_gaps = 1'b0;
    bit stall_request = 1'b0;
    int idle_cycles = 0;

    rgb_to_ycbcr_420 dut (.*);

    ycbcr_420_checker ycc_check (.*);

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int width_used(input int raw);
        int w;
        w = raw & ~1;
        if (w < 2) w = 2;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int height_used(input int raw);
        int h;
        h = raw;
        if (h < 2) h = 2;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        return h;
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                              input logic [PIX_W-1:0] b);
        int gap;
        gap = sender_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        red <= r;
        green <= g;
        blue <= b;
        // ready is stable by the falling edge; the beat goes at the next rising edge
        @(negedge clk);
        while (!in_ready) @(negedge clk);
        @(posedge clk);
        pixels_sent++;
        raster_col++;
        if (raster_col >= frame_width) begin
            raster_col = 0;
            raster_row++;
            if (raster_row >= frame_height) raster_row = 0;
        end
    endtask

    task automatic send_random_pixel();
        logic [PIX_W-1:0] c [3];
        for (int i = 0; i < 3; i++) begin
            case ($urandom_range(0, 9))
                0:       c[i] = '0;
                1:       c[i] = '1;
                default: c[i] = PIX_W'($urandom_range(0, 255));
            endcase
        end
        send_pixel(c[0], c[1], c[2]);
    endtask

    // stop offering and let every pixel in flight come out
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pixels_in_flight != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input int value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[CFG_W-1:0];
        @(posedge clk);
    endtask

    task automatic program_frame(input int width, input int height, input int low,
                                 input int ymax, input int cmax);
        int next_width;
        next_width = width_used(width);
        // a wider row may not start mid-way through an odd row: its pair sums are missing
        while (raster_row % 2 == 1 && next_width > frame_width) send_random_pixel();
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, width);
        write_reg(REG_IMAGE_HEIGHT, height);
        write_reg(REG_CLIP_LOW, low);
        write_reg(REG_LUMA_MAX, ymax);
        write_reg(REG_CHROMA_MAX, cmax);
        cfg_we <= 1'b0;
        frame_width = next_width;
        frame_height = height_used(height);
        if (raster_col >= frame_width) raster_col = 0;
        if (raster_row >= frame_height) raster_row = 0;
    endtask

    // receiver: random ready pattern plus one long hold-off during the wide frame
    initial begin : receiver
        int run;
        int gap;
        bit stalled;
        stalled = 1'b0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (stall_request && !stalled) begin
                out_ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
                stalled = 1'b1;
            end
            run = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 8);
            out_ready <= 1'b1;
            repeat (run) @(posedge clk);
            gap = pick_gap();
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // watchdog: too long without any beat or register write
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : stimulus
        int width;
        int height;
        int low;
        int ymax;
        int cmax;
        int pick;
        bit wide_done;
        wide_done = 1'b0;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_wdata <= '0;
        in_valid <= 1'b0;
        red <= '0;
        green <= '0;
        blue <= '0;
        raster_col = 0;
        raster_row = 0;
        frame_width = width_used(RST_IMAGE_WIDTH);
        frame_height = height_used(RST_IMAGE_HEIGHT);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: primaries, secondaries, gray and alternating bits
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'hFF, 8'h00, 8'h00);
        send_pixel(8'h00, 8'hFF, 8'h00);
        send_pixel(8'h00, 8'h00, 8'hFF);
        send_pixel(8'hFF, 8'hFF, 8'h00);
        send_pixel(8'hFF, 8'h00, 8'hFF);
        send_pixel(8'h00, 8'hFF, 8'hFF);
        send_pixel(8'h80, 8'h80, 8'h80);
        send_pixel(8'h55, 8'hAA, 8'h55);
        send_pixel(8'hAA, 8'h55, 8'hAA);

        // odd width rounds down to 4, the column restarts; full range clipping, one frame
        program_frame(5, 2, 0, 255, 255);
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'hFF, 8'h00, 8'h00);
        send_pixel(8'h00, 8'h00, 8'hFF);
        send_pixel(8'h00, 8'hFF, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'h00, 8'hFF);

        // sizes below the minimum, low limit above both upper limits
        program_frame(1, 1, 255, 0, 0);
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'hFF, 8'h00, 8'h00);
        send_pixel(8'h00, 8'h00, 8'hFF);
        program_frame(0, 0, 200, 100, 50);
        repeat (4) send_random_pixel();

        // random frame settings, one phase at the widest row with a long output stall
        while (pixels_sent < PIXEL_BUDGET) begin
            if (!wide_done && pixels_sent > PIXEL_BUDGET / 3) begin
                program_frame(4095, 2, 16, 235, 240);
                sender_gaps = 1'b0;
                stall_request = 1'b1;
                repeat (WIDE_PIXELS) send_random_pixel();
                stall_request = 1'b0;
                wide_done = 1'b1;
            end
            else begin
                pick = $urandom_range(0, 99);
                if (pick < 65) width = $urandom_range(2, 16);
                else if (pick < 95) width = $urandom_range(17, 80);
                else width = $urandom_range(0, 1);
                pick = $urandom_range(0, 99);
                if (pick < 60) height = $urandom_range(2, 6);
                else if (pick < 90) height = $urandom_range(7, 40);
                else if (pick < 95) height = $urandom_range(0, 1);
                else height = 4095;
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    low = $urandom_range(0, 40);
                    ymax = $urandom_range(200, 255);
                    cmax = $urandom_range(200, 255);
                end
                else if (pick < 85) begin
                    low = $urandom_range(0, 255);
                    ymax = $urandom_range(0, 255);
                    cmax = $urandom_range(0, 255);
                end
                else begin
                    low = $urandom_range(0, 1) * 255;
                    ymax = $urandom_range(0, 1) * 255;
                    cmax = $urandom_range(0, 1) * 255;
                end
                program_frame(width, height, low, ymax, cmax);
                sender_gaps = ($urandom_range(0, 3) != 0);
                repeat ($urandom_range(20, 150)) send_random_pixel();
            end
        end

        wait_idle();
        if (mismatch_count == 0 && pixels_in_flight == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
